// ===== rtl/eerf_pkg.sv =====
// Shared types, constants and arithmetic helpers for the ellipsoid restoring force unit.
`timescale 1ns / 1ps
`default_nettype none
package eerf_pkg;

  localparam logic [63:0] ONE_Q32    = 64'h0000_0001_0000_0000;
  localparam logic [63:0] DELTA_CAP  = 64'h0000_0002_0000_0000;
  localparam int          SQRT_STEPS = 32;
  localparam int          DIV_STEPS  = 64;
  localparam int          CFG_IDX_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_A_SQ    = 8'd0,
    CFG_INV_B_SQ    = 8'd1,
    CFG_INV_C_SQ    = 8'd2,
    CFG_LONGEST_AXIS = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               in_group;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] force_in_x;
    logic signed [31:0] force_in_y;
    logic signed [31:0] force_in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_out_x;
    logic signed [31:0] force_out_y;
    logic signed [31:0] force_out_z;
    logic               outside;
    logic               toward_center;
    logic               saturated;
  } out_t;

  // one square root cell: radicand bits still to consume, partial remainder and root
  typedef struct packed {
    logic        valid;
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqc_t;

  // one divider cell: remainder, dividend bits shifting out / quotient bits shifting in
  typedef struct packed {
    logic        valid;
    logic [63:0] rem;
    logic [63:0] qd;
    logic [63:0] den;
  } dvc_t;

  typedef struct packed {
    logic             outside;
    logic             center;
    logic [4:0]       sh;
    logic [63:0]      k4;
    logic [63:0]      k6;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] frc;
    logic [2:0][39:0] vm;
  } side_t;

  typedef struct packed {
    logic             outside;
    logic             center;
    logic             dzero;
    logic             dsat;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] frc;
    logic [2:0][39:0] vm;
  } tail_t;

  // product shifted right, saturating at 2^64 - 1
  function automatic logic [63:0] shr_sat(input logic [127:0] prod, input int unsigned sh);
    logic [127:0] s;
    s = prod >> sh;
    return (|s[127:64]) ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [63:0] add3_sat(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] c);
    logic [65:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    return (|s[65:64]) ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ellipsoid_envelope_restoring_force_unit.sv =====
// Top level of the ellipsoid envelope restoring force unit.
// Item path from acceptance to out_valid: 12 front stages, 32 root cells,
//   1 operand stage, 64 divider cells, then step, product and output stages.
// Throughput: one item per cycle; every stage advances together, held only while the
//   output register carries an item that is stalled.
// Reset (rst, synchronous, active high) clears every valid bit and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module ellipsoid_envelope_restoring_force_unit import eerf_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire  logic                 clk,
  input  wire  logic                 rst,
  input  wire  logic                 in_valid,
  output logic                       in_stall,
  input  wire  in_t                  in_data,
  output logic                       out_valid,
  input  wire  logic                 out_stall,
  output out_t                       out_data,
  input  wire  logic                 cfg_valid,
  output logic                       cfg_ready,
  input  wire  logic [CFG_IDX_W-1:0] cfg_index,
  input  wire  logic [31:0]          cfg_data
);

  localparam logic [30:0] LONG_AXIS_RST = 31'(64'd1 << COORD_FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Configuration registers: writes always taken; unknown indexes drop.
  // ---------------------------------------------------------------------------
  logic [2:0][31:0] inv;
  logic [30:0]      longest_axis;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv          <= {3{32'h0100_0000}};
      longest_axis <= LONG_AXIS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        CFG_INV_A_SQ:     inv[0]       <= cfg_data;
        CFG_INV_B_SQ:     inv[1]       <= cfg_data;
        CFG_INV_C_SQ:     inv[2]       <= cfg_data;
        CFG_LONGEST_AXIS: longest_axis <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: the whole chain moves unless the output item is held.
  // ---------------------------------------------------------------------------
  logic en;
  logic acc;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign acc      = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Front: moments, discriminant and root operand (gradient or distance case).
  // ---------------------------------------------------------------------------
  sqc_t  sq_ch [0:SQRT_STEPS];
  side_t sd    [0:SQRT_STEPS];

  eerf_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .acc  (acc),
    .item (in_data),
    .inv  (inv),
    .head (sq_ch[0]),
    .side (sd[0])
  );

  // Root chain: one result bit per cell; side data rides alongside.
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    eerf_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (sq_ch[g]),
      .next (sq_ch[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 1; i <= SQRT_STEPS; i++) sd[i] <= sd[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Divider operands: longest_axis / |p| in the distance case, else
  // (k4 - sqrt(D)) / k6. The root is rescaled by the normalising shift.
  // ---------------------------------------------------------------------------
  side_t       sq_end;
  logic [63:0] root_q, num_g, num, den;
  dvc_t        dv_ch [0:DIV_STEPS];
  tail_t       tl    [0:DIV_STEPS];

  always_comb begin
    sq_end = sd[SQRT_STEPS];
    root_q = {32'd0, sq_ch[SQRT_STEPS].root} << sq_end.sh;
    num_g  = (sq_end.k4 > root_q) ? sq_end.k4 - root_q : 64'd0;
    num    = sq_end.center ? {33'd0, longest_axis} : num_g;
    den    = sq_end.center ? {32'd0, sq_ch[SQRT_STEPS].root} : sq_end.k6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ch[0].valid <= 1'b0;
    end else if (en) begin
      dv_ch[0].valid <= sq_ch[SQRT_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ch[0].rem   <= {32'd0, num[63:32]};
      dv_ch[0].qd    <= {num[31:0], 32'd0};
      dv_ch[0].den   <= den;
      tl[0].outside  <= sq_end.outside;
      tl[0].center   <= sq_end.center;
      tl[0].dzero    <= (den == 64'd0);
      // quotient would reach 2^64: clamp it rather than divide
      tl[0].dsat     <= ({32'd0, num[63:32]} >= den);
      tl[0].pos      <= sq_end.pos;
      tl[0].frc      <= sq_end.frc;
      tl[0].vm       <= sq_end.vm;
      for (int i = 1; i <= DIV_STEPS; i++) tl[i] <= tl[i-1];
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    eerf_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (dv_ch[g]),
      .next (dv_ch[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Step factor t (Q32.32 magnitude) and its sign.
  // ---------------------------------------------------------------------------
  tail_t       dv_tail;
  logic [63:0] quo, t_calc;
  logic        tneg_calc;
  logic        t_v, t_neg;
  logic [63:0] t_val;
  tail_t       t_tail;

  always_comb begin
    dv_tail   = tl[DIV_STEPS];
    quo       = dv_tail.dsat ? {64{1'b1}} : dv_ch[DIV_STEPS].qd;
    t_calc    = quo;
    tneg_calc = 1'b0;
    if (dv_tail.dzero) begin
      t_calc = 64'd0;
    end else if (dv_tail.center) begin
      if (quo <= ONE_Q32) begin
        t_calc = ONE_Q32 - quo;
      end else begin
        // inside the sphere of the longest axis: pull points outward
        t_calc    = quo - ONE_Q32;
        tneg_calc = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else if (en) begin
      t_v <= dv_ch[DIV_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_val  <= t_calc;
      t_neg  <= tneg_calc;
      t_tail <= dv_tail;
    end
  end

  // ---------------------------------------------------------------------------
  // Pull magnitude partial products: t (64 bits) by the direction magnitude
  // (40 bits), split into four products of at most 32 by 32.
  // ---------------------------------------------------------------------------
  logic [2:0][39:0] vsel;
  logic             m_v, m_neg;
  tail_t            m_tail;
  logic [2:0][63:0] pp_ll, pp_hl;
  logic [2:0][39:0] pp_lh, pp_hh;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vsel[a] = t_tail.center ? {8'd0, mag32(t_tail.pos[a])} : t_tail.vm[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_neg  <= t_neg;
      m_tail <= t_tail;
      for (int a = 0; a < 3; a++) begin
        pp_ll[a] <= t_val[31:0] * vsel[a][31:0];
        pp_hl[a] <= t_val[63:32] * vsel[a][31:0];
        pp_lh[a] <= t_val[31:0] * vsel[a][39:32];
        pp_hh[a] <= t_val[63:32] * vsel[a][39:32];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: combine, cap the pull, apply it and clamp to 32 bits; forces not outside pass.
  // ---------------------------------------------------------------------------
  logic [2:0][63:0] dm;
  logic [2:0][33:0] mcap;
  logic [2:0]       neg;
  logic [2:0][35:0] sum;
  logic [2:0][31:0] res;
  logic [2:0]       clamp;
  out_t             out_next;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dm[a]   = shr_sat({64'd0, pp_ll[a]} + ({64'd0, pp_hl[a]} << 32)
                        + ({88'd0, pp_lh[a]} << 32) + ({88'd0, pp_hh[a]} << 64), 32);
      mcap[a] = (dm[a] > DELTA_CAP) ? DELTA_CAP[33:0] : dm[a][33:0];
      if (m_tail.pos[a] == 32'd0) mcap[a] = '0;
      // direction opposes the position; a negative step flips it
      neg[a]  = (!m_tail.pos[a][31] && (m_tail.pos[a] != 32'd0)) != m_neg;
      sum[a]  = neg[a] ? {{4{m_tail.frc[a][31]}}, m_tail.frc[a]} - {2'b00, mcap[a]}
                       : {{4{m_tail.frc[a][31]}}, m_tail.frc[a]} + {2'b00, mcap[a]};
      clamp[a] = 1'b1;
      if (!sum[a][35] && (sum[a][34:31] != 4'd0)) begin
        res[a] = 32'h7fff_ffff;
      end else if (sum[a][35] && (sum[a][34:31] != 4'hf)) begin
        res[a] = 32'h8000_0000;
      end else begin
        res[a]   = sum[a][31:0];
        clamp[a] = 1'b0;
      end
      if (!m_tail.outside) begin
        res[a]   = m_tail.frc[a];
        clamp[a] = 1'b0;
      end
    end
    out_next.force_out_x   = res[0];
    out_next.force_out_y   = res[1];
    out_next.force_out_z   = res[2];
    out_next.outside       = m_tail.outside;
    out_next.toward_center = m_tail.outside && m_tail.center;
    out_next.saturated     = |clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_center_implies_outside : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.toward_center |-> out_data.outside)
    else $error("center pull flagged for a particle not outside");

  a_sat_implies_outside : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |-> out_data.outside)
    else $error("clamp flagged on an untouched force");

  a_tneg_only_center : assert property (@(posedge clk) disable iff (rst)
    t_v && t_neg |-> t_tail.center)
    else $error("negative step outside the distance case");

endmodule
`default_nettype wire

// ===== rtl/eerf_sqrt_cell.sv =====
// One digit step of the restoring square root chain.
`timescale 1ns / 1ps
`default_nettype none
module eerf_sqrt_cell import eerf_pkg::*; (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic en,
  input  wire  sqc_t prev,
  output sqc_t       next
);

  logic [35:0] rem_ext;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    rem_ext = {prev.rem, prev.rad[63:62]};
    trial   = {2'b00, prev.root, 2'b01};
    ge      = (rem_ext >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next.rad  <= {prev.rad[61:0], 2'b00};
      next.rem  <= ge ? 34'(rem_ext - trial) : 34'(rem_ext);
      next.root <= {prev.root[30:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/eerf_div_cell.sv =====
// One quotient bit step of the restoring divider chain.
`timescale 1ns / 1ps
`default_nettype none
module eerf_div_cell import eerf_pkg::*; (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic en,
  input  wire  dvc_t prev,
  output dvc_t       next
);

  logic [64:0] rem_ext;
  logic        ge;

  always_comb begin
    rem_ext = {prev.rem, prev.qd[63]};
    ge      = (rem_ext >= {1'b0, prev.den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next.rem <= ge ? 64'(rem_ext - {1'b0, prev.den}) : rem_ext[63:0];
      next.qd  <= {prev.qd[62:0], ge};
      next.den <= prev.den;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/eerf_front.sv =====
// Front pipeline: weighted moments k2/k4/k6, discriminant and square root operand.
`timescale 1ns / 1ps
`default_nettype none
module eerf_front import eerf_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire  logic             clk,
  input  wire  logic             rst,
  input  wire  logic             en,
  input  wire  logic             acc,
  input  wire  in_t              item,
  input  wire  logic [2:0][31:0] inv,
  output sqc_t                   head,
  output side_t                  side
);

  localparam int unsigned T2_SHIFT = 2 * COORD_FRAC_BITS - 8;

  logic [11:1]      vld;
  in_t              it [1:11];
  logic [63:0]      ss [3:11];
  logic [2:0][39:0] vmc [3:11];

  logic [2:0][31:0] pos1, pm1;
  logic [2:0][63:0] sq2, vmp2;
  logic [2:0][63:0] pp3_hi, pp3_lo, t2_4, pp5_hi, pp5_lo, t4_6, pp7_hi, pp7_lo, t6_8;
  logic [63:0]      k2_5, k2_6, k2_7, k2_8, k2_9;
  logic [63:0]      k4_7, k4_8, k4_9, k4_10, k4_11;
  logic [63:0]      k6_9, k6_10, k6_11;
  logic [63:0]      a_ll, a_lh, a_hh, b_ll, b_lh, b_hl, b_hh;
  logic [63:0]      a11, b11;
  logic             out10, out11;
  logic [63:0]      e9, d12;
  logic             ctr12;
  logic [4:0]       nrm_s;

  always_comb begin
    pos1 = {it[1].pos_z, it[1].pos_y, it[1].pos_x};
    for (int a = 0; a < 3; a++) begin
      pm1[a] = mag32(pos1[a]);
    end
    e9    = k2_9 - ONE_Q32;
    ctr12 = (b11 > a11);
    d12   = a11 - b11;
    // normalise by whole bit pairs, at most sixteen of them
    nrm_s = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (d12 >= (64'd1 << (62 - 2 * i))) nrm_s = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      head.valid <= 1'b0;
    end else if (en) begin
      vld        <= {vld[10:1], acc};
      head.valid <= vld[11];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[1] <= item;
      for (int i = 2; i <= 11; i++) it[i] <= it[i-1];
      for (int i = 4; i <= 11; i++) begin
        ss[i]  <= ss[i-1];
        vmc[i] <= vmc[i-1];
      end
      for (int a = 0; a < 3; a++) begin
        sq2[a]    <= pm1[a] * pm1[a];
        vmp2[a]   <= pm1[a] * inv[a];
        pp3_hi[a] <= sq2[a][63:32] * inv[a];
        pp3_lo[a] <= sq2[a][31:0] * inv[a];
        vmc[3][a] <= vmp2[a][63:24];
        t2_4[a]   <= shr_sat(({64'd0, pp3_hi[a]} << 32) + {64'd0, pp3_lo[a]}, T2_SHIFT);
        pp5_hi[a] <= t2_4[a][63:32] * inv[a];
        pp5_lo[a] <= t2_4[a][31:0] * inv[a];
        t4_6[a]   <= shr_sat(({64'd0, pp5_hi[a]} << 32) + {64'd0, pp5_lo[a]}, 24);
        pp7_hi[a] <= t4_6[a][63:32] * inv[a];
        pp7_lo[a] <= t4_6[a][31:0] * inv[a];
        t6_8[a]   <= shr_sat(({64'd0, pp7_hi[a]} << 32) + {64'd0, pp7_lo[a]}, 24);
      end
      ss[3] <= sq2[0] + sq2[1] + sq2[2];
      k2_5  <= add3_sat(t2_4[0], t2_4[1], t2_4[2]);
      k2_6  <= k2_5;
      k2_7  <= k2_6;
      k4_7  <= add3_sat(t4_6[0], t4_6[1], t4_6[2]);
      k2_8  <= k2_7;
      k4_8  <= k4_7;
      k2_9  <= k2_8;
      k4_9  <= k4_8;
      k6_9  <= add3_sat(t6_8[0], t6_8[1], t6_8[2]);
      // k4^2 uses the cross term once, doubled on combining
      a_ll  <= k4_9[31:0] * k4_9[31:0];
      a_lh  <= k4_9[31:0] * k4_9[63:32];
      a_hh  <= k4_9[63:32] * k4_9[63:32];
      b_ll  <= k6_9[31:0] * e9[31:0];
      b_lh  <= k6_9[31:0] * e9[63:32];
      b_hl  <= k6_9[63:32] * e9[31:0];
      b_hh  <= k6_9[63:32] * e9[63:32];
      out10 <= it[9].in_group && (k2_9 > ONE_Q32);
      k4_10 <= k4_9;
      k6_10 <= k6_9;
      a11   <= shr_sat({64'd0, a_ll} + ({64'd0, a_lh} << 33) + ({64'd0, a_hh} << 64), 32);
      b11   <= shr_sat({64'd0, b_ll} + ({64'd0, b_lh} << 32) + ({64'd0, b_hl} << 32)
                       + ({64'd0, b_hh} << 64), 32);
      out11 <= out10;
      k4_11 <= k4_10;
      k6_11 <= k6_10;
      head.rad     <= ctr12 ? ss[11] : (d12 << {nrm_s, 1'b0});
      head.rem     <= '0;
      head.root    <= '0;
      side.outside <= out11;
      side.center  <= out11 && ctr12;
      side.sh      <= 5'(5'd16 - nrm_s);
      side.k4      <= k4_11;
      side.k6      <= k6_11;
      side.pos     <= {it[11].pos_z, it[11].pos_y, it[11].pos_x};
      side.frc     <= {it[11].force_in_z, it[11].force_in_y, it[11].force_in_x};
      side.vm      <= vmc[11];
    end
  end

endmodule
`default_nettype wire
